/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL of the trie block, included by trie_insert_and_lookup.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant violated");
// When pre holds, post must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle check violated");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

/* hw/rtl/trie_pkg.sv */
// Shared types and constants for the trie insert and lookup block.
// No dependencies; used by trie_store and trie_insert_and_lookup.
`default_nettype none

package trie_pkg;

  // Field widths fixed by the item and result formats.
  localparam int LETTER_W   = 5;
  localparam int NODE_IDX_W = 12;
  localparam int COUNT_W    = 16;

  // Opcodes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  // Saturation value of a word count.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // One letter of a word.
  typedef struct packed {
    logic                opcode;
    logic [LETTER_W-1:0] letter;
    logic                last_letter;
  } item_t;

  // One result, produced on the last letter of a word.
  typedef struct packed {
    logic                  found;
    logic [NODE_IDX_W-1:0] node_index;
    logic [COUNT_W-1:0]    word_count;
    logic                  pool_full;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/trie_store.sv */
// Node pool storage: child edge memory and per-node memory (parent link, letter, count).
// Depends on trie_pkg. Validates a child edge against its back-link so no clear is needed.
`default_nettype none

module trie_store #(
  parameter int NODE_COUNT = 4096,
  parameter int ALPHABET   = 26,
  localparam int NODE_W    = $clog2(NODE_COUNT),
  localparam int USED_W    = $clog2(NODE_COUNT + 1),
  localparam int SLOT_W    = $clog2(NODE_COUNT * ALPHABET)
) (
  input  wire logic                           clk,
  // Current cursor and letter, used for the edge check and for node writes.
  input  wire logic [NODE_W-1:0]              cursor,
  input  wire logic [trie_pkg::LETTER_W-1:0]  letter,
  input  wire logic [USED_W-1:0]              nodes_used,
  // Child edge memory port: one address for read and write.
  input  wire logic [SLOT_W-1:0]              child_addr,
  input  wire logic                           child_rd_en,
  input  wire logic                           child_wr_en,
  input  wire logic [NODE_W-1:0]              child_wr_data,
  // Node memory: read at the child just fetched, write at a chosen node.
  input  wire logic                           node_rd_en,
  input  wire logic                           node_wr_en,
  input  wire logic [NODE_W-1:0]              node_wr_addr,
  input  wire logic [trie_pkg::COUNT_W-1:0]   node_wr_count,
  output logic [NODE_W-1:0]                   child,
  output logic                                edge_hit,
  output logic [trie_pkg::COUNT_W-1:0]        node_count
);

  localparam int ENTRY_W    = NODE_W + trie_pkg::LETTER_W + trie_pkg::COUNT_W;
  localparam int SLOT_COUNT = NODE_COUNT * ALPHABET;

  bit   [NODE_W-1:0]              child_mem [SLOT_COUNT];
  bit   [ENTRY_W-1:0]             node_mem  [NODE_COUNT];
  logic [NODE_W-1:0]              child_q;
  logic [ENTRY_W-1:0]             entry_q;
  logic [NODE_W-1:0]              entry_parent;
  logic [trie_pkg::LETTER_W-1:0]  entry_letter;

  // Child edge memory with registered read data.
  always_ff @(posedge clk) begin
    if (child_wr_en) begin
      child_mem[child_addr] <= child_wr_data;
    end
    if (child_rd_en) begin
      child_q <= child_mem[child_addr];
    end
  end

  // Node memory; the read address is the registered child edge.
  always_ff @(posedge clk) begin
    if (node_wr_en) begin
      node_mem[node_wr_addr] <= {cursor, letter, node_wr_count};
    end
    if (node_rd_en) begin
      entry_q <= node_mem[child_q];
    end
  end

  assign entry_parent = entry_q[ENTRY_W-1 -: NODE_W];
  assign entry_letter = entry_q[trie_pkg::COUNT_W +: trie_pkg::LETTER_W];

  // An edge is real only if it names an allocated node whose back-link
  // points at this cursor and letter; stale or never-written slots fail.
  assign edge_hit = (child_q != '0) && (USED_W'(child_q) < nodes_used) &&
                    (entry_parent == cursor) && (entry_letter == letter);

  assign child      = child_q;
  assign node_count = entry_q[trie_pkg::COUNT_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/trie_insert_and_lookup.sv */
// Trie insert/lookup: each letter steps through child edge read, node read, and decide and write.
// A letter of a word already missed or full, or out of range, goes to a skip step without memory reads.
// The result is registered from the decide and write step (from the skip step for a skipped letter).
// A last letter holds the input off while the output register still waits for its transfer.
// Reset clears control state; no memory clearing pass is needed, since
// edges are checked against node back-links and the allocation count.
// Depends on trie_pkg, trie_store and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module trie_insert_and_lookup #(
  parameter int NODE_COUNT = 4096,
  parameter int ALPHABET   = 26
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire trie_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output trie_pkg::result_t      result
);

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int USED_W = $clog2(NODE_COUNT + 1);
  localparam int SLOT_W = $clog2(NODE_COUNT * ALPHABET);
  localparam logic [8:0] ALPHA_LIM = 9'(ALPHABET);
  localparam logic [USED_W-1:0] USED_MAX = USED_W'(NODE_COUNT);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHILD = 4'b0010,
    ST_NODE  = 4'b0100,
    ST_SKIP  = 4'b1000
  } state_t;

  state_t                         state, state_next;
  logic [NODE_W-1:0]              cursor, cursor_next;
  logic                           missed, missed_next;
  logic                           full, full_next;
  logic [USED_W-1:0]              nodes_used, nodes_used_next;
  logic                           op_reg;
  logic [trie_pkg::LETTER_W-1:0]  letter_reg;
  logic                           last_reg;

  logic [trie_pkg::LETTER_W-1:0]  addr_letter;
  logic [SLOT_W-1:0]              child_addr;
  logic                           letter_bad;
  logic                           child_rd_en, child_wr_en, node_rd_en, node_wr_en;
  logic [trie_pkg::COUNT_W-1:0]   node_wr_count;
  logic [NODE_W-1:0]              child;
  logic                           edge_hit;
  logic [trie_pkg::COUNT_W-1:0]   node_count;

  logic                           out_free;
  logic                           produce;
  trie_pkg::result_t              result_next;
  logic                           advance, alloc, step_missed, step_full, inc;
  logic [NODE_W-1:0]              step_node;
  logic [trie_pkg::COUNT_W-1:0]   step_count, count_new;
  logic                           alloc_done;

  // Edge slot address: from the incoming letter at transfer, else from the held letter.
  assign addr_letter = (state == ST_IDLE) ? item.letter : letter_reg;
  assign child_addr  = SLOT_W'(cursor) * SLOT_W'(ALPHABET) + SLOT_W'(addr_letter);
  assign letter_bad  = (9'(item.letter) >= ALPHA_LIM);

  assign item_ready = (state == ST_IDLE);
  assign out_free   = !result_valid || result_ready;

  trie_store #(
    .NODE_COUNT (NODE_COUNT),
    .ALPHABET   (ALPHABET)
  ) u_store (
    .clk           (clk),
    .cursor        (cursor),
    .letter        (letter_reg),
    .nodes_used    (nodes_used),
    .child_addr    (child_addr),
    .child_rd_en   (child_rd_en),
    .child_wr_en   (child_wr_en),
    .child_wr_data (nodes_used[NODE_W-1:0]),
    .node_rd_en    (node_rd_en),
    .node_wr_en    (node_wr_en),
    .node_wr_addr  (step_node),
    .node_wr_count (node_wr_count),
    .child         (child),
    .edge_hit      (edge_hit),
    .node_count    (node_count)
  );

  // Step decision: follow the edge, allocate a node, or record miss or full.
  always_comb begin
    advance     = 1'b0;
    alloc       = 1'b0;
    step_missed = 1'b0;
    step_full   = 1'b0;
    step_node   = cursor;
    step_count  = node_count;
    if (edge_hit) begin
      advance    = 1'b1;
      step_node  = child;
    end else if (op_reg == trie_pkg::OP_FIND) begin
      step_missed = 1'b1;
    end else if (nodes_used >= USED_MAX) begin
      step_full = 1'b1;
    end else begin
      alloc      = 1'b1;
      advance    = 1'b1;
      step_node  = nodes_used[NODE_W-1:0];
      step_count = '0;
    end
    inc       = (op_reg == trie_pkg::OP_INSERT) && (step_count != trie_pkg::COUNT_MAX);
    count_new = inc ? step_count + trie_pkg::COUNT_W'(1) : step_count;
  end

  // Sequencer: next state, memory strobes and the result.
  always_comb begin
    state_next      = state;
    cursor_next     = cursor;
    missed_next     = missed;
    full_next       = full;
    nodes_used_next = nodes_used;
    child_rd_en     = 1'b0;
    child_wr_en     = 1'b0;
    node_rd_en      = 1'b0;
    node_wr_en      = 1'b0;
    node_wr_count   = '0;
    produce         = 1'b0;
    result_next     = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (missed || full || letter_bad) begin
            state_next = ST_SKIP;
          end else begin
            child_rd_en = 1'b1;
            state_next  = ST_CHILD;
          end
        end
      end
      ST_CHILD: begin
        node_rd_en = 1'b1;
        state_next = ST_NODE;
      end
      ST_NODE: begin
        // A last letter waits here until the output register is free.
        if (!last_reg || out_free) begin
          state_next    = ST_IDLE;
          child_wr_en   = alloc;
          node_wr_en    = alloc || (last_reg && advance && inc);
          node_wr_count = last_reg ? count_new : '0;
          if (alloc) begin
            nodes_used_next = nodes_used + USED_W'(1);
          end
          if (last_reg) begin
            produce                = 1'b1;
            result_next.found      = advance;
            result_next.node_index = advance ? trie_pkg::NODE_IDX_W'(step_node) : '0;
            result_next.word_count = advance ? count_new : '0;
            result_next.pool_full  = step_full;
            cursor_next            = '0;
            missed_next            = 1'b0;
            full_next              = 1'b0;
          end else begin
            cursor_next = step_node;
            missed_next = step_missed;
            full_next   = step_full;
          end
        end
      end
      ST_SKIP: begin
        // Word already missed or full, or the letter is out of range.
        if (!last_reg || out_free) begin
          state_next = ST_IDLE;
          if (last_reg) begin
            produce               = 1'b1;
            result_next.pool_full = full;
            cursor_next           = '0;
            missed_next           = 1'b0;
            full_next             = 1'b0;
          end else begin
            missed_next = missed || !full;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cursor     <= '0;
      missed     <= 1'b0;
      full       <= 1'b0;
      nodes_used <= USED_W'(1);
    end else begin
      state      <= state_next;
      cursor     <= cursor_next;
      missed     <= missed_next;
      full       <= full_next;
      nodes_used <= nodes_used_next;
    end
  end

  // Hold the transferred letter for the duration of its step.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      op_reg     <= item.opcode;
      letter_reg <= item.letter;
      last_reg   <= item.last_letter;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (produce) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      result <= result_next;
    end
  end

  // An allocating step that completes this cycle.
  assign alloc_done = (state == ST_NODE) && alloc && (state_next == ST_IDLE);

  // Checks on allocation and cursor bookkeeping.
  `ASSERT_ALWAYS(a_used_range, clk, rst, (nodes_used != '0) && (nodes_used <= USED_MAX))
  `ASSERT_ALWAYS(a_cursor_alloc, clk, rst, USED_W'(cursor) < nodes_used)
  `ASSERT_NEXT(a_alloc_step, clk, rst, alloc_done, nodes_used == $past(nodes_used) + USED_W'(1))
  `ASSERT_NEXT(a_word_end, clk, rst, produce, (cursor == '0) && !missed && !full && result_valid)

endmodule

`default_nettype wire

/* sim/trie_insert_and_lookup_test.sv */
// Self-checking testbench for trie_insert_and_lookup: directed letters and random words,
// with a long result hold-off and a full drain, checked against an in-bench trie model.
// Depends on trie_pkg and the trie_insert_and_lookup RTL.
`default_nettype none

module trie_insert_and_lookup_test;

  localparam int NODES     = 4096;
  localparam int LETTERS   = 26;
  localparam int LIMIT     = 400_000;
  localparam int HOLD_LEN  = 300;
  localparam int RAND_GOAL = 1280;
  localparam int NUM_ROWS  = 23;

  // One row of the directed script; chk marks rows whose result is typed in.
  typedef struct packed {
    logic                          opcode;
    logic [trie_pkg::LETTER_W-1:0] letter;
    logic                          last_letter;
    bit                            chk;
    bit                            found;
    bit [trie_pkg::NODE_IDX_W-1:0] node_index;
    bit [trie_pkg::COUNT_W-1:0]    word_count;
    bit                            pool_full;
  } script_row_t;

  // A word of up to eight letters.
  typedef struct packed {
    bit [3:0]                           len;
    bit [7:0][trie_pkg::LETTER_W-1:0]   ch;
  } word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  trie_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  trie_pkg::result_t result;

  // Model state of the trie.
  bit [trie_pkg::NODE_IDX_W-1:0] child_of [NODES*LETTERS];
  bit [trie_pkg::COUNT_W-1:0]    insert_count [NODES];
  int                            nodes_used = 1;
  bit [trie_pkg::NODE_IDX_W-1:0] cursor = '0;
  bit                            word_missed = 1'b0;
  bit                            word_full = 1'b0;

  trie_pkg::result_t pending_results [$];
  word_t             vocab [$];
  int                mismatches = 0;
  int                cycles = 0;
  int                letters_sent = 0;
  bit                no_idle = 1'b0;
  bit                hold_req = 1'b0;

  // Directed script: empty trie, extremes of the letter field, out-of-range
  // letters, misses, mixed opcodes in one word and a prefix with no count.
  script_row_t script [0:NUM_ROWS-1] = '{
    '{trie_pkg::OP_FIND,   5'd0,  1'b1, 1'b1, 1'b0, 12'd0, 16'd0, 1'b0},
    '{trie_pkg::OP_INSERT, 5'd0,  1'b1, 1'b1, 1'b1, 12'd1, 16'd1, 1'b0},
    '{trie_pkg::OP_INSERT, 5'd25, 1'b1, 1'b1, 1'b1, 12'd2, 16'd1, 1'b0},
    '{trie_pkg::OP_INSERT, 5'd0,  1'b1, 1'b1, 1'b1, 12'd1, 16'd2, 1'b0},
    '{trie_pkg::OP_FIND,   5'd0,  1'b1, 1'b1, 1'b1, 12'd1, 16'd2, 1'b0},
    '{trie_pkg::OP_INSERT, 5'd31, 1'b1, 1'b1, 1'b0, 12'd0, 16'd0, 1'b0},
    '{trie_pkg::OP_FIND,   5'd26, 1'b1, 1'b1, 1'b0, 12'd0, 16'd0, 1'b0},
    '{trie_pkg::OP_INSERT, 5'd0,  1'b0, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0},
    '{trie_pkg::OP_INSERT, 5'd1,  1'b1, 1'b1, 1'b1, 12'd3, 16'd1, 1'b0},
    '{trie_pkg::OP_FIND,   5'd2,  1'b0, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0},
    '{trie_pkg::OP_INSERT, 5'd0,  1'b1, 1'b1, 1'b0, 12'd0, 16'd0, 1'b0},
    '{trie_pkg::OP_INSERT, 5'd0,  1'b0, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0},
    '{trie_pkg::OP_FIND,   5'd1,  1'b1, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0},
    '{trie_pkg::OP_FIND,   5'd0,  1'b0, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0},
    '{trie_pkg::OP_INSERT, 5'd3,  1'b1, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0},
    '{trie_pkg::OP_INSERT, 5'd16, 1'b0, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0},
    '{trie_pkg::OP_INSERT, 5'd30, 1'b0, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0},
    '{trie_pkg::OP_INSERT, 5'd4,  1'b1, 1'b1, 1'b0, 12'd0, 16'd0, 1'b0},
    '{trie_pkg::OP_FIND,   5'd16, 1'b1, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0},
    '{trie_pkg::OP_INSERT, 5'd25, 1'b0, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0},
    '{trie_pkg::OP_INSERT, 5'd15, 1'b1, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0},
    '{trie_pkg::OP_FIND,   5'd25, 1'b0, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0},
    '{trie_pkg::OP_FIND,   5'd15, 1'b1, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0}
  };

  trie_insert_and_lookup #(
    .NODE_COUNT(NODES),
    .ALPHABET(LETTERS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Walk one letter through the model trie; returns 1 when the letter ends a word.
  function automatic bit walk_letter(input trie_pkg::item_t it, output trie_pkg::result_t res);
    bit                            is_ins;
    int                            slot;
    bit [trie_pkg::NODE_IDX_W-1:0] nxt;
    is_ins = (it.opcode == trie_pkg::OP_INSERT);
    res = '0;
    if (!word_missed && !word_full) begin
      if (it.letter >= LETTERS) begin
        word_missed = 1'b1;
      end else begin
        slot = int'(cursor) * LETTERS + int'(it.letter);
        nxt = child_of[slot];
        if (nxt == '0) begin
          if (!is_ins) begin
            word_missed = 1'b1;
          end else if (nodes_used >= NODES) begin
            word_full = 1'b1;
          end else begin
            nxt = trie_pkg::NODE_IDX_W'(nodes_used);
            nodes_used++;
            child_of[slot] = nxt;
          end
        end
        if (!word_missed && !word_full) cursor = nxt;
      end
    end
    if (!it.last_letter) return 1'b0;
    if (word_missed || word_full) begin
      res.pool_full = word_full;
    end else begin
      if (is_ins && insert_count[cursor] != trie_pkg::COUNT_MAX) insert_count[cursor]++;
      res.found = 1'b1;
      res.node_index = cursor;
      res.word_count = insert_count[cursor];
    end
    cursor = '0;
    word_missed = 1'b0;
    word_full = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // Offer one letter after a random gap and record its expected result on transfer.
  task automatic send_letter(input trie_pkg::item_t it, input bit chk,
                             input trie_pkg::result_t want);
    int                gap;
    trie_pkg::result_t got;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    letters_sent++;
    if (walk_letter(it, got)) pending_results.push_back(chk ? want : got);
  endtask

  task automatic send_word(input word_t w, input bit [7:0] ops);
    trie_pkg::item_t it;
    for (int i = 0; i < w.len; i++) begin
      it.opcode = ops[i];
      it.letter = w.ch[i];
      it.last_letter = (i == w.len - 1);
      send_letter(it, 1'b0, '0);
    end
  endtask

  // One random word: mostly inserts and finds, often of known words, some noise.
  task automatic random_word();
    word_t    w;
    bit [7:0] ops;
    int       kind;
    bit       narrow;
    kind = $urandom_range(0, 99);
    narrow = $urandom_range(0, 1);
    w.len = 4'($urandom_range(1, 6));
    for (int i = 0; i < 8; i++) begin
      w.ch[i] = narrow ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, LETTERS - 1));
    end
    if (kind < 40) begin
      ops = {8{trie_pkg::OP_INSERT}};
      if (vocab.size() < 64) vocab.push_back(w);
      else vocab[$urandom_range(0, 63)] = w;
    end else if (kind < 75) begin
      ops = {8{trie_pkg::OP_FIND}};
      if (vocab.size() > 0 && $urandom_range(0, 9) < 7) begin
        w = vocab[$urandom_range(0, vocab.size() - 1)];
        if ($urandom_range(0, 2) == 0) w.len = 4'($urandom_range(1, w.len));
      end
    end else if (kind < 85) begin
      ops = {8{trie_pkg::OP_INSERT}};
      if (vocab.size() > 0) w = vocab[$urandom_range(0, vocab.size() - 1)];
    end else begin
      ops = 8'($urandom);
      for (int i = 0; i < 8; i++) w.ch[i] = 5'($urandom_range(0, 31));
    end
    send_word(w, ops);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_side
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_LEN;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    trie_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no expected result");
      end else begin
        want = pending_results.pop_front();
        if (result.found !== want.found)
          report_mismatch($sformatf("found %b, expected %b", result.found, want.found));
        if (result.node_index !== want.node_index)
          report_mismatch($sformatf("node_index %0d, expected %0d",
                                    result.node_index, want.node_index));
        if (result.word_count !== want.word_count)
          report_mismatch($sformatf("word_count %0d, expected %0d",
                                    result.word_count, want.word_count));
        if (result.pool_full !== want.pool_full)
          report_mismatch($sformatf("pool_full %b, expected %b",
                                    result.pool_full, want.pool_full));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    trie_pkg::item_t   it;
    trie_pkg::result_t want;
    int                rand_start;
    int                words;
    bit                held;
    bit                drained;
    held = 1'b0;
    drained = 1'b0;
    words = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed script.
    for (int r = 0; r < NUM_ROWS; r++) begin
      it.opcode = script[r].opcode;
      it.letter = script[r].letter;
      it.last_letter = script[r].last_letter;
      want.found = script[r].found;
      want.node_index = script[r].node_index;
      want.word_count = script[r].word_count;
      want.pool_full = script[r].pool_full;
      send_letter(it, script[r].chk, want);
    end

    // Random words, with a long result hold-off and a full drain on the way.
    rand_start = letters_sent;
    while (letters_sent - rand_start < RAND_GOAL) begin
      if (words % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (!held && letters_sent - rand_start >= 500) begin
        held = 1'b1;
        hold_req = 1'b1;
        no_idle = 1'b1;
        for (int i = 0; i < 40; i++) begin
          it.opcode = 1'($urandom_range(0, 1));
          it.letter = 5'($urandom_range(0, 3));
          it.last_letter = 1'b1;
          send_letter(it, 1'b0, '0);
        end
        no_idle = 1'b0;
      end
      if (!drained && letters_sent - rand_start >= 1000) begin
        drained = 1'b1;
        item_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      random_word();
      words++;
    end

    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
